[hw/rtl/vsap_pkg.sv]
// Package for the vertex set axis projection core.
// Holds shared types, sizing constants and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vsap_pkg;

  localparam int unsigned FieldW          = 32;
  localparam int unsigned FractionBitsDef = 16;
  localparam int unsigned CoordWidthDef   = 32;
  localparam int unsigned SumW            = 68;
  localparam int unsigned QDepth          = 4;

  typedef logic signed [FieldW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef enum logic [2:0] {
    KIND_ROT,
    KIND_TRANS,
    KIND_AXIS,
    KIND_VERT,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] row;
    vec_t       v;
    logic       last;
  } item_t;

  typedef enum logic [1:0] {
    OP_VERT,
    OP_AXIS,
    OP_WORLD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] idx;
    logic       last;
    vec_t       v;
  } tag_t;

  typedef struct packed {
    logic   valid;
    vec_t   a;
    vec_t   b;
    coord_t extra;
    tag_t   tag;
  } dot_req_t;

  typedef struct packed {
    logic   valid;
    logic   busy;
    coord_t value;
    tag_t   tag;
  } dot_res_t;

  function automatic coord_t sat(input logic signed [SumW-1:0] v, input int unsigned w);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = (SumW'(1) << (w - 1)) - SumW'(1);
    lo = ~hi;
    if (v > hi) return hi[FieldW-1:0];
    if (v < lo) return lo[FieldW-1:0];
    return v[FieldW-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/vsap_front.sv]
// Front end: decodes and clamps incoming transactions into a short queue.
// Depends on vsap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsap_front #(
  parameter int unsigned CoordWidth = vsap_pkg::CoordWidthDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [1:0]            req_type_i,
  input  wire  [1:0]            row_index_i,
  input  wire  vsap_pkg::coord_t value_a_i,
  input  wire  vsap_pkg::coord_t value_b_i,
  input  wire  vsap_pkg::coord_t value_c_i,
  input  wire                   last_i,
  input  wire                   pop_i,
  output logic                  q_valid_o,
  output vsap_pkg::item_t       q_item_o
);
  import vsap_pkg::*;

  localparam int unsigned EffW = (CoordWidth < FieldW) ? CoordWidth : FieldW;
  localparam int unsigned PtrW = $clog2(QDepth);

  item_t            mem_q [QDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    cnt_q;
  item_t            item;
  logic             push, pop;

  always_comb begin
    item.row    = row_index_i;
    item.last   = last_i;
    item.v.x    = sat(SumW'(value_a_i), EffW);
    item.v.y    = sat(SumW'(value_b_i), EffW);
    item.v.z    = sat(SumW'(value_c_i), EffW);
    case (req_type_i)
      2'd0:    item.kind = (row_index_i == 2'd3) ? KIND_NOP : KIND_ROT;
      2'd1:    item.kind = KIND_TRANS;
      2'd2:    item.kind = KIND_AXIS;
      default: item.kind = KIND_VERT;
    endcase
  end

  assign in_ready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        mem_q[wptr_q] <= item;
        wptr_q        <= wptr_q + 1'b1;
      end
      if (pop) rptr_q <= rptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/vsap_dot.sv]
// Two-stage Q-format dot product unit: three products, then sum and saturate.
// Depends on vsap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsap_dot #(
  parameter int unsigned FractionBits = vsap_pkg::FractionBitsDef,
  parameter int unsigned CoordWidth   = vsap_pkg::CoordWidthDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  vsap_pkg::dot_req_t  req_i,
  output vsap_pkg::dot_res_t  res_o
);
  import vsap_pkg::*;

  localparam int unsigned EffW  = (CoordWidth < FieldW) ? CoordWidth : FieldW;
  localparam int unsigned ProdW = 2 * FieldW;

  logic signed [ProdW-1:0] m0, m1, m2;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q;
  coord_t                  extra_q, value_q;
  tag_t                    tag1_q, tag2_q;
  logic                    s1_v_q, s2_v_q;
  logic signed [SumW-1:0]  sum;

  assign m0  = ProdW'(req_i.a.x) * ProdW'(req_i.b.x);
  assign m1  = ProdW'(req_i.a.y) * ProdW'(req_i.b.y);
  assign m2  = ProdW'(req_i.a.z) * ProdW'(req_i.b.z);
  assign sum = SumW'(p0_q) + SumW'(p1_q) + SumW'(p2_q) + SumW'(extra_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q  <= req_i.valid;
      s2_v_q  <= s1_v_q;
      p0_q    <= m0 >>> FractionBits;
      p1_q    <= m1 >>> FractionBits;
      p2_q    <= m2 >>> FractionBits;
      extra_q <= req_i.extra;
      tag1_q  <= req_i.tag;
      value_q <= sat(sum, EffW);
      tag2_q  <= tag1_q;
    end
  end

  assign res_o.valid = s2_v_q;
  assign res_o.busy  = s1_v_q || s2_v_q;
  assign res_o.value = value_q;
  assign res_o.tag   = tag2_q;

endmodule
`default_nettype wire

[hw/rtl/vsap_back.sv]
// Back end: sequences loads, projections and world transforms on the dot unit
// and holds the result register. Depends on vsap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsap_back #(
  parameter int unsigned CoordWidth = vsap_pkg::CoordWidthDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   q_valid_i,
  input  vsap_pkg::item_t       q_item_i,
  output logic                  pop_o,
  output vsap_pkg::dot_req_t    req_o,
  input  vsap_pkg::dot_res_t    res_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output vsap_pkg::coord_t      min_projection_o,
  output vsap_pkg::coord_t      max_projection_o,
  output vsap_pkg::coord_t      min_x_o,
  output vsap_pkg::coord_t      min_y_o,
  output vsap_pkg::coord_t      min_z_o,
  output vsap_pkg::coord_t      max_x_o,
  output vsap_pkg::coord_t      max_y_o,
  output vsap_pkg::coord_t      max_z_o
);
  import vsap_pkg::*;

  localparam int unsigned EffW = (CoordWidth < FieldW) ? CoordWidth : FieldW;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_AXIS,
    ST_LASTWAIT,
    ST_WORLD,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e     state_q;
  logic [2:0] cnt_q;
  logic       emit_pend_q, seen_q;
  vec_t       rot_q [3];
  vec_t       trans_q, lax_q, axis_v_q, minv_q, maxv_q;
  coord_t     offset_q, rmin_q, rmax_q;
  coord_t     world_q [6];
  coord_t     out_q [8];
  logic       out_free;
  logic [1:0] wrow;
  coord_t     wtrans;

  assign out_free = !out_valid_o || out_ready_i;
  assign wrow     = (cnt_q < 3'd3) ? cnt_q[1:0] : 2'(cnt_q - 3'd3);

  always_comb begin
    case (wrow)
      2'd0:    wtrans = trans_q.x;
      2'd1:    wtrans = trans_q.y;
      default: wtrans = trans_q.z;
    endcase
  end

  always_comb begin
    req_o = '0;
    pop_o = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (q_valid_i) begin
          pop_o        = 1'b1;
          req_o.tag.v  = q_item_i.v;
          req_o.tag.last = q_item_i.last;
          req_o.b      = q_item_i.v;
          case (q_item_i.kind)
            KIND_VERT: begin
              req_o.valid  = 1'b1;
              req_o.tag.op = OP_VERT;
              req_o.a      = lax_q;
            end
            KIND_AXIS: begin
              req_o.valid  = 1'b1;
              req_o.tag.op = OP_AXIS;
              req_o.a      = '{x: rot_q[0].x, y: rot_q[1].x, z: rot_q[2].x};
            end
            default: req_o.valid = 1'b0;
          endcase
        end
      end
      ST_AXIS: begin
        req_o.valid   = 1'b1;
        req_o.tag.op  = OP_AXIS;
        req_o.tag.idx = cnt_q;
        req_o.b       = axis_v_q;
        case (cnt_q)
          3'd1:    req_o.a = '{x: rot_q[0].y, y: rot_q[1].y, z: rot_q[2].y};
          3'd2:    req_o.a = '{x: rot_q[0].z, y: rot_q[1].z, z: rot_q[2].z};
          default: req_o.a = trans_q;
        endcase
      end
      ST_WORLD: begin
        req_o.valid   = 1'b1;
        req_o.tag.op  = OP_WORLD;
        req_o.tag.idx = cnt_q;
        req_o.a       = rot_q[wrow];
        req_o.b       = (cnt_q < 3'd3) ? minv_q : maxv_q;
        req_o.extra   = wtrans;
      end
      default: req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      emit_pend_q <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && (state_q != ST_EMIT)) out_valid_o <= 1'b0;

      if (res_i.valid) begin
        case (res_i.tag.op)
          OP_VERT: begin
            if (!seen_q || (res_i.value < rmin_q)) begin
              rmin_q <= res_i.value;
              minv_q <= res_i.tag.v;
            end
            if (!seen_q || (res_i.value > rmax_q)) begin
              rmax_q <= res_i.value;
              maxv_q <= res_i.tag.v;
            end
            seen_q <= 1'b1;
          end
          OP_AXIS: begin
            case (res_i.tag.idx)
              3'd0:    lax_q.x  <= res_i.value;
              3'd1:    lax_q.y  <= res_i.value;
              3'd2:    lax_q.z  <= res_i.value;
              default: offset_q <= res_i.value;
            endcase
          end
          default: world_q[res_i.tag.idx] <= res_i.value;
        endcase
      end

      case (state_q)
        ST_RUN: begin
          if (q_valid_i) begin
            case (q_item_i.kind)
              KIND_ROT:   rot_q[q_item_i.row] <= q_item_i.v;
              KIND_TRANS: trans_q <= q_item_i.v;
              KIND_AXIS: begin
                axis_v_q <= q_item_i.v;
                cnt_q    <= 3'd1;
                state_q  <= ST_AXIS;
              end
              KIND_VERT: if (q_item_i.last) state_q <= ST_LASTWAIT;
              default: state_q <= ST_RUN;
            endcase
          end
        end
        ST_AXIS: begin
          if (cnt_q == 3'd3) begin
            emit_pend_q <= 1'b0;
            state_q     <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_LASTWAIT: begin
          if (!res_i.busy) begin
            cnt_q   <= '0;
            state_q <= ST_WORLD;
          end
        end
        ST_WORLD: begin
          if (cnt_q == 3'd5) begin
            emit_pend_q <= 1'b1;
            state_q     <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        ST_DRAIN: begin
          if (!res_i.busy) state_q <= emit_pend_q ? ST_EMIT : ST_RUN;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_q[0]    <= sat(SumW'(rmin_q) + SumW'(offset_q), EffW);
            out_q[1]    <= sat(SumW'(rmax_q) + SumW'(offset_q), EffW);
            out_q[2]    <= world_q[0];
            out_q[3]    <= world_q[1];
            out_q[4]    <= world_q[2];
            out_q[5]    <= world_q[3];
            out_q[6]    <= world_q[4];
            out_q[7]    <= world_q[5];
            out_valid_o <= 1'b1;
            seen_q      <= 1'b0;
            state_q     <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign min_projection_o = out_q[0];
  assign max_projection_o = out_q[1];
  assign min_x_o          = out_q[2];
  assign min_y_o          = out_q[3];
  assign min_z_o          = out_q[4];
  assign max_x_o          = out_q[5];
  assign max_y_o          = out_q[6];
  assign max_z_o          = out_q[7];

endmodule
`default_nettype wire

[hw/rtl/vertex_set_axis_projection_core.sv]
// Top level of the vertex set axis projection core.
// Instantiates vsap_front, vsap_dot and vsap_back; depends on vsap_pkg.
//
// Usage: the input channel (in_valid_i / in_ready_o) carries setup and vertex
// transactions: rotation rows, translation, world axis, then a vertex stream
// whose final vertex has last_i set. The output channel (out_valid_o /
// out_ready_i) carries one result per vertex set: min and max projection
// plus offset, and both extreme vertices in world space.
// A four-entry queue decouples intake from the back-end sequencer.
// Rotation, translation and non-final vertices pass the sequencer back to back
// while the queue holds items. An axis load holds the sequencer for the
// issue, three more dot products through the two-stage dot unit and a drain.
// A final vertex holds it for the projection drain, six world-space dot
// products, a drain, and the result load once the result register is free.
// A stalled receiver holds the result register; the queue keeps accepting
// until it fills, then in_ready_o drops.
// Reset clears the queue, sequencer and result valid; loaded setup registers are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module vertex_set_axis_projection_core #(
  parameter int unsigned FRACTION_BITS = vsap_pkg::FractionBitsDef,
  parameter int unsigned COORD_WIDTH   = vsap_pkg::CoordWidthDef
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [1:0]             req_type_i,
  input  wire  [1:0]             row_index_i,
  input  wire  vsap_pkg::coord_t value_a_i,
  input  wire  vsap_pkg::coord_t value_b_i,
  input  wire  vsap_pkg::coord_t value_c_i,
  input  wire                    last_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output vsap_pkg::coord_t       min_projection_o,
  output vsap_pkg::coord_t       max_projection_o,
  output vsap_pkg::coord_t       min_x_o,
  output vsap_pkg::coord_t       min_y_o,
  output vsap_pkg::coord_t       min_z_o,
  output vsap_pkg::coord_t       max_x_o,
  output vsap_pkg::coord_t       max_y_o,
  output vsap_pkg::coord_t       max_z_o
);
  import vsap_pkg::*;

  logic     q_valid, pop;
  item_t    q_item;
  dot_req_t dreq;
  dot_res_t dres;

  vsap_front #(.CoordWidth(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .req_type_i, .row_index_i, .value_a_i, .value_b_i, .value_c_i, .last_i,
    .pop_i(pop), .q_valid_o(q_valid), .q_item_o(q_item)
  );

  vsap_dot #(.FractionBits(FRACTION_BITS), .CoordWidth(COORD_WIDTH)) u_dot (
    .clk_i, .rst_ni, .req_i(dreq), .res_o(dres)
  );

  vsap_back #(.CoordWidth(COORD_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .pop_o(pop),
    .req_o(dreq), .res_i(dres), .out_valid_o, .out_ready_i,
    .min_projection_o, .max_projection_o, .min_x_o, .min_y_o, .min_z_o,
    .max_x_o, .max_y_o, .max_z_o
  );

endmodule
`default_nettype wire

[hw/rtl/vsap_checker.sv]
// Port-level checker for the projection core, bound to the top level.
// Depends on vsap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vsap_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire  [1:0]             req_type_i,
  input wire                    last_i,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input wire  vsap_pkg::coord_t min_projection_o,
  input wire  vsap_pkg::coord_t max_x_o
);
  import vsap_pkg::*;

  logic [3:0] pend_q;
  logic       in_last, out_take;

  assign in_last  = in_valid_i && in_ready_o && (req_type_i == 2'd3) && last_i;
  assign out_take = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {3'd0, in_last} - {3'd0, out_take};
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(min_projection_o) && $stable(max_x_o))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0) else $error("result without final vertex");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd6) else $error("too many pending sets");

endmodule

bind vertex_set_axis_projection_core vsap_checker u_vsap_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .last_i,
  .out_valid_o, .out_ready_i, .min_projection_o, .max_x_o
);
`default_nettype wire
